[rtl/shell_command_lexer_assert.svh]
// Assertion macros used by the lexer port checker.
`ifndef SHELL_COMMAND_LEXER_ASSERT_SVH
`define SHELL_COMMAND_LEXER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SCL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define SCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

[rtl/shl_pkg.sv]
// Shared types and constants for the shell command lexer.
package shl_pkg;

  typedef logic [12:0] opos_t;

  localparam logic [2:0] K_PIPE    = 3'd0;
  localparam logic [2:0] K_IN      = 3'd1;
  localparam logic [2:0] K_HEREDOC = 3'd2;
  localparam logic [2:0] K_OUT     = 3'd3;
  localparam logic [2:0] K_APPEND  = 3'd4;
  localparam logic [2:0] K_WORD    = 3'd5;
  localparam logic [2:0] K_END     = 3'd6;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_LT   = 3'd1;
  localparam logic [2:0] M_GT   = 3'd2;
  localparam logic [2:0] M_WORD = 3'd3;
  localparam logic [2:0] M_SQ   = 3'd4;
  localparam logic [2:0] M_DQ   = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [2:0] kind;
    opos_t      start_pos;
    opos_t      end_pos;
  } tok_t;

  // Every token one character causes: cnt is 1 to 3.
  typedef struct packed {
    logic [1:0]      cnt;
    tok_t [2:0]      toks;
  } bnd_t;

endpackage

[rtl/shl_front.sv]
// Front end: classifies each character, tracks lexer state, builds token bundles.
module shl_front #(
  parameter int MAX_LINE = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        ch,
  input  logic              line_end,
  output logic              bnd_vld,
  output shl_pkg::bnd_t     bnd
);

  localparam int POS_W = $clog2(MAX_LINE + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]       mode_r, mode_nxt;
  logic             quoted_r, quoted_nxt;
  logic [POS_W-1:0] tstart_r, tstart_nxt;

  function automatic shl_pkg::bnd_t emit(shl_pkg::bnd_t b, logic [2:0] k,
                                          shl_pkg::opos_t s, shl_pkg::opos_t e);
    shl_pkg::tok_t t;
    t.kind      = k;
    t.start_pos = s;
    t.end_pos   = e;
    if (b.cnt != 2'd3) begin
      b.toks[b.cnt] = t;
      b.cnt         = b.cnt + 2'd1;
    end
    return b;
  endfunction

  always_comb begin
    logic [POS_W-1:0] p, p1, ts;
    logic [2:0]       m;
    logic             q, ended, do_idle, is_ws;
    shl_pkg::bnd_t    b;
    p       = pos_r;
    p1      = (p >= POS_MAX) ? POS_MAX : p + 1'b1;
    m       = mode_r;
    q       = quoted_r;
    ts      = tstart_r;
    b       = '0;
    ended   = 1'b0;
    do_idle = 1'b0;
    is_ws   = (ch == shl_pkg::CH_SPACE) || (ch == shl_pkg::CH_TAB) ||
              (ch == shl_pkg::CH_CR) || (ch == shl_pkg::CH_LF) ||
              (ch == shl_pkg::CH_VT);
    case (mode_r)
      shl_pkg::M_LT, shl_pkg::M_GT: begin
        if (ch == ((mode_r == shl_pkg::M_LT) ? shl_pkg::CH_LT : shl_pkg::CH_GT)) begin
          b = emit(b, (mode_r == shl_pkg::M_LT) ? shl_pkg::K_HEREDOC : shl_pkg::K_APPEND,
                   shl_pkg::opos_t'(ts), shl_pkg::opos_t'(p1));
          m = shl_pkg::M_IDLE;
        end else begin
          b = emit(b, (mode_r == shl_pkg::M_LT) ? shl_pkg::K_IN : shl_pkg::K_OUT,
                   shl_pkg::opos_t'(ts), shl_pkg::opos_t'(p));
          m       = shl_pkg::M_IDLE;
          do_idle = 1'b1;
        end
      end
      shl_pkg::M_WORD: begin
        if ((ch == shl_pkg::CH_NUL) || (ch == shl_pkg::CH_LT) ||
            (ch == shl_pkg::CH_GT) || (ch == shl_pkg::CH_PIPE) ||
            (quoted_r ? (ch == shl_pkg::CH_SPACE) : is_ws)) begin
          b = emit(b, shl_pkg::K_WORD, shl_pkg::opos_t'(ts), shl_pkg::opos_t'(p));
          m       = shl_pkg::M_IDLE;
          do_idle = 1'b1;
        end else if (ch == shl_pkg::CH_SQ) begin
          m = shl_pkg::M_SQ;
        end else if (ch == shl_pkg::CH_DQ) begin
          m = shl_pkg::M_DQ;
        end
      end
      shl_pkg::M_SQ, shl_pkg::M_DQ: begin
        if (ch == shl_pkg::CH_NUL) begin
          b = emit(b, shl_pkg::K_WORD, shl_pkg::opos_t'(ts), shl_pkg::opos_t'(p));
          b = emit(b, shl_pkg::K_END, shl_pkg::opos_t'(p), shl_pkg::opos_t'(p));
          ended = 1'b1;
        end else if (ch == ((mode_r == shl_pkg::M_SQ) ? shl_pkg::CH_SQ : shl_pkg::CH_DQ)) begin
          m = shl_pkg::M_WORD;
        end
      end
      default: begin
        m       = shl_pkg::M_IDLE;
        do_idle = 1'b1;
      end
    endcase
    if (do_idle) begin
      if (ch == shl_pkg::CH_NUL) begin
        b = emit(b, shl_pkg::K_END, shl_pkg::opos_t'(p), shl_pkg::opos_t'(p));
        ended = 1'b1;
      end else if (is_ws) begin
        m = shl_pkg::M_IDLE;
      end else if (ch == shl_pkg::CH_PIPE) begin
        b = emit(b, shl_pkg::K_PIPE, shl_pkg::opos_t'(p), shl_pkg::opos_t'(p1));
        m = shl_pkg::M_IDLE;
      end else if ((ch == shl_pkg::CH_LT) || (ch == shl_pkg::CH_GT)) begin
        ts = p;
        m  = (ch == shl_pkg::CH_LT) ? shl_pkg::M_LT : shl_pkg::M_GT;
      end else if ((ch == shl_pkg::CH_SQ) || (ch == shl_pkg::CH_DQ)) begin
        ts = p;
        q  = 1'b1;
        m  = (ch == shl_pkg::CH_SQ) ? shl_pkg::M_SQ : shl_pkg::M_DQ;
      end else begin
        ts = p;
        q  = 1'b0;
        m  = shl_pkg::M_WORD;
      end
    end
    if (!ended && line_end) begin
      if (m == shl_pkg::M_LT) begin
        b = emit(b, shl_pkg::K_IN, shl_pkg::opos_t'(ts), shl_pkg::opos_t'(p1));
      end else if (m == shl_pkg::M_GT) begin
        b = emit(b, shl_pkg::K_OUT, shl_pkg::opos_t'(ts), shl_pkg::opos_t'(p1));
      end else if ((m == shl_pkg::M_WORD) || (m == shl_pkg::M_SQ) || (m == shl_pkg::M_DQ)) begin
        b = emit(b, shl_pkg::K_WORD, shl_pkg::opos_t'(ts), shl_pkg::opos_t'(p1));
      end
      b = emit(b, shl_pkg::K_END, shl_pkg::opos_t'(p1), shl_pkg::opos_t'(p1));
      ended = 1'b1;
    end
    bnd = b;
    if (!accept) begin
      pos_nxt    = pos_r;
      mode_nxt   = mode_r;
      quoted_nxt = quoted_r;
      tstart_nxt = tstart_r;
    end else if (ended) begin
      pos_nxt    = '0;
      mode_nxt   = shl_pkg::M_IDLE;
      quoted_nxt = 1'b0;
      tstart_nxt = '0;
    end else begin
      pos_nxt    = p1;
      mode_nxt   = m;
      quoted_nxt = q;
      tstart_nxt = ts;
    end
  end

  assign bnd_vld = accept && (bnd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      mode_r   <= shl_pkg::M_IDLE;
      quoted_r <= 1'b0;
      tstart_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      mode_r   <= mode_nxt;
      quoted_r <= quoted_nxt;
      tstart_r <= tstart_nxt;
    end
  end

endmodule

[rtl/shl_queue.sv]
// Short bundle queue between the front end and the token serializer.
module shl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  shl_pkg::bnd_t wr_data,
  input  logic          rd_en,
  output shl_pkg::bnd_t rd_data,
  output logic          full,
  output logic          empty
);

  shl_pkg::bnd_t                  mem_r [shl_pkg::QDEPTH];
  logic [shl_pkg::QPTR_W-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [shl_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  assign full    = (cnt_r == shl_pkg::QCNT_W'(shl_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/shl_back.sv]
// Back end: holds one bundle and hands out its tokens one request at a time.
module shl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  shl_pkg::bnd_t       q_data,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic [2:0]          token_kind,
  output shl_pkg::opos_t      start_pos,
  output shl_pkg::opos_t      end_pos,
  output logic                last_of_run
);

  shl_pkg::bnd_t bnd_r, bnd_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          vld_r, vld_nxt;
  logic          last;
  shl_pkg::tok_t cur;

  assign last        = (idx_r == (bnd_r.cnt - 2'd1));
  assign cur         = bnd_r.toks[idx_r];
  assign empty       = !vld_r;
  assign token_kind  = cur.kind;
  assign start_pos   = cur.start_pos;
  assign end_pos     = cur.end_pos;
  assign last_of_run = last;

  always_comb begin
    bnd_nxt = bnd_r;
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    q_pop   = 1'b0;
    if (!vld_r || (pop && last)) begin
      q_pop   = !q_empty;
      vld_nxt = !q_empty;
      bnd_nxt = q_data;
      idx_nxt = 2'd0;
    end else if (pop) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    bnd_r <= bnd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

endmodule

[rtl/shell_command_lexer.sv]
// Top level of the shell command lexer: front end, bundle queue, serializer.
//
//  channel  | ports                                    | handshake
//  ---------+------------------------------------------+---------------------
//  input    | in_ch, in_line_end                       | in_push / in_full
//  result   | out_token_kind, out_start_pos,           | out_pop / out_empty
//           | out_end_pos, out_last_of_run             |
//
// One character is taken per cycle while the four-deep bundle queue has room.
// Each character yields zero to three tokens; the serializer delivers one token
// per cycle while out_pop is high; three-token characters are output-bound.
// Each token is registered in the bundle queue and then in the serializer.
// Synchronous active-low reset clears the lexer state and empties the queue.
// Either side may stall freely; a waiting token holds until popped.
module shell_command_lexer #(
  parameter int MAX_LINE = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_ch,
  input  logic        in_line_end,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_token_kind,
  output logic [12:0] out_start_pos,
  output logic [12:0] out_end_pos,
  output logic        out_last_of_run
);

  logic          accept;
  logic          bnd_vld;
  shl_pkg::bnd_t bnd;
  shl_pkg::bnd_t q_data;
  logic          q_pop, q_empty;

  assign accept = in_push && !in_full;

  shl_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .ch       (in_ch),
    .line_end (in_line_end),
    .bnd_vld  (bnd_vld),
    .bnd      (bnd)
  );

  shl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bnd_vld),
    .wr_data (bnd),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (in_full),
    .empty   (q_empty)
  );

  shl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .pop         (out_pop),
    .empty       (out_empty),
    .token_kind  (out_token_kind),
    .start_pos   (out_start_pos),
    .end_pos     (out_end_pos),
    .last_of_run (out_last_of_run)
  );

endmodule

[rtl/shl_checker.sv]
// Port-level checks for the shell command lexer, bound to the top level.
`include "shell_command_lexer_assert.svh"

module shl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic [7:0]  in_ch,
  input logic        in_line_end,
  input logic        out_empty,
  input logic        out_pop,
  input logic [2:0]  out_token_kind,
  input logic [12:0] out_start_pos,
  input logic [12:0] out_end_pos,
  input logic        out_last_of_run
);

  `SCL_ASSERT_NEXT(a_stall_hold, !out_empty && !out_pop, !out_empty && $stable(out_token_kind) && $stable(out_start_pos) && $stable(out_end_pos) && $stable(out_last_of_run))

  `SCL_ASSERT_NOW(a_kind_range, !out_empty, out_token_kind <= shl_pkg::K_END)

  `SCL_ASSERT_NOW(a_end_zero_len, !out_empty && (out_token_kind == shl_pkg::K_END), out_start_pos == out_end_pos)

  `SCL_ASSERT_NOW(a_end_is_last, !out_empty && (out_token_kind == shl_pkg::K_END), out_last_of_run)

endmodule

bind shell_command_lexer shl_checker u_shl_checker (.*);

[bench/shell_command_lexer_checker.sv]
`timescale 1ns / 1ps
// Token checker for the shell command lexer: predicts tokens per character and compares them.
module shell_command_lexer_checker #(
  parameter int LINE_CAP = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_ch,
  input  logic        in_line_end,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [2:0]  out_token_kind,
  input  logic [12:0] out_start_pos,
  input  logic [12:0] out_end_pos,
  input  logic        out_last_of_run,
  output int          mismatches,
  output int          tokens_waiting
);
  import shl_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    opos_t      start_pos;
    opos_t      end_pos;
    logic       last;
  } token_t;

  token_t     pending_tokens[$];
  opos_t      char_pos;
  opos_t      tok_start;
  logic [2:0] mode;
  logic       began_quoted;

  initial begin
    mismatches = 0;
    tokens_waiting = 0;
  end

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_VT;
  endfunction

  function automatic bit is_op(input logic [7:0] c);
    return c == CH_LT || c == CH_PIPE || c == CH_GT;
  endfunction

  function automatic void add_token(input logic [2:0] kind, input opos_t s, input opos_t e,
                                    inout int n);
    token_t t;
    if (n < 3) begin
      t = '{kind, s, e, 1'b0};
      pending_tokens.push_back(t);
      n++;
    end
  endfunction

  // Handles a character as if between tokens; returns 1 when it closed the line.
  function automatic bit open_token(input logic [7:0] c, input opos_t p, input opos_t p1,
                                    inout int n);
    bit closed;
    closed = 1'b0;
    if (c == CH_NUL) begin
      add_token(K_END, p, p, n);
      closed = 1'b1;
    end else if (is_blank(c)) begin
      mode = M_IDLE;
    end else if (c == CH_PIPE) begin
      add_token(K_PIPE, p, p1, n);
      mode = M_IDLE;
    end else if (c == CH_LT || c == CH_GT) begin
      tok_start = p;
      mode = (c == CH_LT) ? M_LT : M_GT;
    end else if (c == CH_SQ || c == CH_DQ) begin
      tok_start = p;
      began_quoted = 1'b1;
      mode = (c == CH_SQ) ? M_SQ : M_DQ;
    end else begin
      tok_start = p;
      began_quoted = 1'b0;
      mode = M_WORD;
    end
    return closed;
  endfunction

  function automatic void lex_char(input logic [7:0] c, input logic le);
    opos_t  p;
    opos_t  p1;
    bit     closed;
    bit     stop;
    int     n;
    token_t t;
    p = char_pos;
    p1 = (p >= LINE_CAP) ? opos_t'(LINE_CAP) : p + 13'd1;
    closed = 1'b0;
    n = 0;
    case (mode)
      M_LT, M_GT: begin
        if (c == ((mode == M_LT) ? CH_LT : CH_GT)) begin
          add_token((mode == M_LT) ? K_HEREDOC : K_APPEND, tok_start, p1, n);
          mode = M_IDLE;
        end else begin
          add_token((mode == M_LT) ? K_IN : K_OUT, tok_start, p, n);
          mode = M_IDLE;
          closed = open_token(c, p, p1, n);
        end
      end
      M_WORD: begin
        stop = (c == CH_NUL) || is_op(c) || (began_quoted ? (c == CH_SPACE) : is_blank(c));
        if (stop) begin
          add_token(K_WORD, tok_start, p, n);
          mode = M_IDLE;
          closed = open_token(c, p, p1, n);
        end else if (c == CH_SQ) begin
          mode = M_SQ;
        end else if (c == CH_DQ) begin
          mode = M_DQ;
        end
      end
      M_SQ, M_DQ: begin
        if (c == CH_NUL) begin
          add_token(K_WORD, tok_start, p, n);
          add_token(K_END, p, p, n);
          closed = 1'b1;
        end else if (c == ((mode == M_SQ) ? CH_SQ : CH_DQ)) begin
          mode = M_WORD;
        end
      end
      default: begin
        mode = M_IDLE;
        closed = open_token(c, p, p1, n);
      end
    endcase
    if (!closed && le) begin
      if (mode == M_LT)
        add_token(K_IN, tok_start, p1, n);
      else if (mode == M_GT)
        add_token(K_OUT, tok_start, p1, n);
      else if (mode == M_WORD || mode == M_SQ || mode == M_DQ)
        add_token(K_WORD, tok_start, p1, n);
      add_token(K_END, p1, p1, n);
      closed = 1'b1;
    end
    if (closed) begin
      char_pos = '0;
      mode = M_IDLE;
      began_quoted = 1'b0;
      tok_start = '0;
    end else begin
      char_pos = p1;
    end
    if (n > 0) begin
      t = pending_tokens.pop_back();
      t.last = 1'b1;
      pending_tokens.push_back(t);
    end
  endfunction

  function automatic void check_field(input string name, input logic [12:0] want,
                                      input logic [12:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    token_t want;
    if (!rst_n) begin
      char_pos = '0;
      mode = M_IDLE;
      began_quoted = 1'b0;
      tok_start = '0;
      pending_tokens.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_tokens.size() == 0) begin
          $display("%0t: token with none expected, expected nothing, got kind %0d start %0d end %0d",
                   $time, out_token_kind, out_start_pos, out_end_pos);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", want.kind, out_token_kind);
          check_field("start_pos", want.start_pos, out_start_pos);
          check_field("end_pos", want.end_pos, out_end_pos);
          check_field("last_of_run", want.last, out_last_of_run);
        end
      end
      if (in_push && !in_full)
        lex_char(in_ch, in_line_end);
    end
    tokens_waiting = pending_tokens.size();
  end

endmodule

[bench/shell_command_lexer_test.sv]
`timescale 1ns / 1ps
// Testbench top for the shell command lexer: stimulus, handshake pacing and verdict.
module shell_command_lexer_test;
  import shl_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_ch = 8'h00;
  logic        in_line_end = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_token_kind;
  logic [12:0] out_start_pos;
  logic [12:0] out_end_pos;
  logic        out_last_of_run;

  int mismatches;
  int tokens_waiting;
  int pop_stall = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always #5 clk = ~clk;

  shell_command_lexer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_ch          (in_ch),
    .in_line_end    (in_line_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_token_kind (out_token_kind),
    .out_start_pos  (out_start_pos),
    .out_end_pos    (out_end_pos),
    .out_last_of_run(out_last_of_run)
  );

  shell_command_lexer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_ch          (in_ch),
    .in_line_end    (in_line_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_token_kind (out_token_kind),
    .out_start_pos  (out_start_pos),
    .out_end_pos    (out_end_pos),
    .out_last_of_run(out_last_of_run),
    .mismatches     (mismatches),
    .tokens_waiting (tokens_waiting)
  );

  task automatic send_char(input logic [7:0] c, input logic le);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_ch <= c;
    in_line_end <= le;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], close && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] blank_char();
    logic [7:0] blanks[5];
    blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_VT};
    return blanks[$urandom_range(0, 4)];
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0)
      return 8'($urandom_range(128, 255));
    do c = 8'($urandom_range(33, 126));
    while (c == CH_DQ || c == CH_SQ || c == CH_LT || c == CH_GT || c == CH_PIPE);
    return c;
  endfunction

  // One command line of random tokens; a few lines are raw byte noise.
  task automatic send_random_line(output int sent);
    logic [7:0] line[$];
    logic [7:0] q;
    logic [7:0] c;
    logic       last_flag;
    int         ntok;
    if ($urandom_range(0, 6) == 0) begin
      sent = $urandom_range(1, 8);
      repeat (sent) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end else begin
      ntok = $urandom_range(1, 5);
      repeat (ntok) begin
        repeat ($urandom_range(0, 2)) line.push_back(blank_char());
        case ($urandom_range(0, 7))
          0: line.push_back(CH_PIPE);
          1: line.push_back(CH_LT);
          2: begin
            line.push_back(CH_LT);
            line.push_back(CH_LT);
          end
          3: line.push_back(CH_GT);
          4: begin
            line.push_back(CH_GT);
            line.push_back(CH_GT);
          end
          default: begin
            repeat ($urandom_range(1, 4)) begin
              if ($urandom_range(0, 3) == 0) begin
                q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
                line.push_back(q);
                repeat ($urandom_range(0, 3)) begin
                  do c = 8'($urandom_range(1, 255)); while (c == q);
                  line.push_back(c);
                end
                if ($urandom_range(0, 7) != 0)
                  line.push_back(q);
              end else begin
                line.push_back(plain_char());
              end
            end
          end
        endcase
      end
      if ($urandom_range(0, 4) == 0)
        line.push_back(blank_char());
      if ($urandom_range(0, 3) == 0) begin
        line.push_back(CH_NUL);
        last_flag = $urandom_range(0, 1);
      end else begin
        last_flag = 1'b1;
      end
      foreach (line[i])
        send_char(line[i], (i == line.size() - 1) ? last_flag : 1'b0);
      sent = line.size();
    end
  endtask

  // Receiver pacing: random stall bursts, one long hold-off once asked.
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (pop_stall > 0) begin
        out_pop <= 1'b0;
        pop_stall--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        pop_stall = 399;
        out_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        pop_stall = $urandom_range(0, 15);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    int sent;
    int n;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // quoted word keeps tab and VT, redirect followed by other redirect
    send_text("\t<>|'x\ty'", 1'b0);
    send_char(CH_VT, 1'b1);
    send_text("a<<b>>", 1'b0);
    send_char(CH_NUL, 1'b0);
    // unclosed quote to line end, top byte value
    send_text("\"q", 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("<|", 1'b1);
    send_text("w>", 1'b1);
    // NUL inside a quote
    send_text("'z", 1'b0);
    send_char(CH_NUL, 1'b1);

    // input redirect closed by a word that runs to the line end
    send_char(CH_SPACE, 1'b0);
    send_char(CH_PIPE, 1'b0);
    send_char(CH_LT, 1'b0);
    send_char("b", 1'b0);
    send_char("c", 1'b1);

    hold_req = 1'b1;
    sent = 0;
    while (sent < 350) begin
      if (sent >= 290)
        calm = 1'b1;
      send_random_line(n);
      sent += n;
    end
    @(negedge clk);
    in_push <= 1'b0;

    while (tokens_waiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[shell_command_lexer.f]
+incdir+rtl
rtl/shl_pkg.sv
rtl/shl_front.sv
rtl/shl_queue.sv
rtl/shl_back.sv
rtl/shell_command_lexer.sv
rtl/shl_checker.sv
bench/shell_command_lexer_checker.sv
bench/shell_command_lexer_test.sv
